@@ sv/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion macros for the decoder RTL. Each expects signals named
// clock and reset in the module that uses it.

// Checked on every rising edge except while reset is high.
`define CBD_ASSERT_CLK(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define CBD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

@@ sv/cbd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package cbd_pkg;

   localparam int unsigned DefaultSizeDigits = 8;
   localparam int unsigned ByteW = 8;
   localparam int unsigned SizeW = 32;
   localparam int unsigned TrailBytes = 2;

   localparam logic [ByteW-1:0] CharCr = 8'h0d;
   localparam logic [ByteW-1:0] CharLf = 8'h0a;
   localparam logic [3:0] HexMask = 4'hf;
   localparam logic [4:0] HexLetterOffset = 5'd9;
   localparam logic [4:0] HexInvalid = 5'd16;

   typedef enum logic [2:0] {
      PH_SIZE  = 3'd0,
      PH_EXT   = 3'd1,
      PH_LF    = 3'd2,
      PH_DATA  = 3'd3,
      PH_TRAIL = 3'd4,
      PH_IDLE  = 3'd5
   } phase_type;

   typedef enum logic [1:0] {
      KIND_DATA = 2'd0,
      KIND_END  = 2'd1,
      KIND_OVF  = 2'd2
   } kind_type;

   typedef struct packed {
      logic [ByteW-1:0] in_byte;
      logic             body_start;
   } item_type;

   typedef struct packed {
      logic [ByteW-1:0] out_byte;
      kind_type         kind;
   } result_type;

   // Value 0..15 of a hex digit in either case, HexInvalid for any other byte.
   function automatic logic [4:0] hex_value(input logic [ByteW-1:0] b);
      logic [4:0] low;
      low = {1'b0, b[3:0] & HexMask};
      if (b >= 8'h30 && b <= 8'h39) begin
         return low;
      end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
         return low + HexLetterOffset;
      end else begin
         return HexInvalid;
      end
   endfunction

endpackage

`default_nettype wire

@@ sv/cbd_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cbd_req_if import cbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] in_byte;
   logic             body_start;

   modport source (output valid, output in_byte, output body_start, input ready);
   modport sink (input valid, input in_byte, input body_start, output ready);
endinterface

`default_nettype wire

@@ sv/cbd_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface cbd_rsp_if import cbd_pkg::*; ();
   logic             valid;
   logic             ready;
   logic [ByteW-1:0] out_byte;
   logic [1:0]       kind;

   modport source (output valid, output out_byte, output kind, input ready);
   modport sink (input valid, input out_byte, input kind, output ready);
endinterface

`default_nettype wire

@@ sv/cbd_input_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbd_input_stage import cbd_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   cbd_req_if.sink   req,
   input  wire logic take,
   output logic      item_valid,
   output item_type  item
);

   logic     in_valid_ff;
   logic     in_valid_in;
   item_type item_ff;
   logic     load;

   // The register may refill in the same cycle that the parser drains it.
   assign req.ready = !in_valid_ff || take;
   assign load = req.valid && req.ready;
   assign in_valid_in = load || (in_valid_ff && !take);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         item_ff.in_byte <= req.in_byte;
         item_ff.body_start <= req.body_start;
      end
   end

   assign item_valid = in_valid_ff;
   assign item = item_ff;

endmodule

`default_nettype wire

@@ sv/cbd_parser.sv @@
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module cbd_parser import cbd_pkg::*; #(
   parameter int unsigned SIZE_DIGITS = DefaultSizeDigits
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       item_valid,
   input  wire item_type   item,
   input  wire logic       out_free,
   output logic            take,
   output logic            res_load,
   output result_type      res
);

   localparam int unsigned CntMax = (SIZE_DIGITS > TrailBytes) ? SIZE_DIGITS : TrailBytes;
   localparam int unsigned CntW = $clog2(CntMax + 1);

   phase_type        phase_ff, phase_in;
   logic [SizeW-1:0] rem_ff, rem_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;

   phase_type        phase_cur;
   logic [SizeW-1:0] rem_cur;
   logic [CntW-1:0]  cnt_cur;
   logic [CntW-1:0]  cnt_dec;
   logic [4:0]       digit;
   logic             res_valid;

   // Next state and result for the item in the input register. A start flag
   // restarts the size line before the byte itself is looked at.
   always_comb begin
      phase_cur = item.body_start ? PH_SIZE : phase_ff;
      rem_cur = item.body_start ? '0 : rem_ff;
      cnt_cur = item.body_start ? '0 : cnt_ff;
      digit = hex_value(item.in_byte);
      cnt_dec = cnt_cur - CntW'(cnt_cur != '0);

      phase_in = phase_cur;
      rem_in = rem_cur;
      cnt_in = cnt_cur;
      res_valid = 1'b0;
      res.out_byte = '0;
      res.kind = KIND_DATA;

      case (phase_cur)
         PH_SIZE: begin
            if (item.in_byte == CharCr) begin
               phase_in = PH_LF;
            end else if (digit != HexInvalid) begin
               if (cnt_cur >= CntW'(SIZE_DIGITS)) begin
                  phase_in = PH_IDLE;
                  res_valid = 1'b1;
                  res.kind = KIND_OVF;
               end else begin
                  rem_in = {rem_cur[SizeW-5:0], digit[3:0]};
                  cnt_in = cnt_cur + CntW'(1);
               end
            end else begin
               phase_in = PH_EXT;
            end
         end
         PH_EXT: begin
            if (item.in_byte == CharCr) begin
               phase_in = PH_LF;
            end
         end
         PH_LF: begin
            if (item.in_byte == CharLf) begin
               if (rem_cur != '0) begin
                  phase_in = PH_DATA;
               end else begin
                  phase_in = PH_IDLE;
                  res_valid = 1'b1;
                  res.kind = KIND_END;
               end
            end else if (item.in_byte != CharCr) begin
               phase_in = PH_EXT;
            end
         end
         PH_DATA: begin
            res_valid = 1'b1;
            res.out_byte = item.in_byte;
            rem_in = rem_cur - SizeW'(1);
            if (rem_cur == SizeW'(1)) begin
               phase_in = PH_TRAIL;
               cnt_in = CntW'(TrailBytes);
            end
         end
         PH_TRAIL: begin
            if (cnt_dec == '0) begin
               phase_in = PH_SIZE;
               rem_in = '0;
               cnt_in = '0;
            end else begin
               cnt_in = cnt_dec;
            end
         end
         default: begin
         end
      endcase
   end

   assign take = item_valid && (!res_valid || out_free);
   assign res_load = take && res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SIZE;
         rem_ff <= '0;
         cnt_ff <= '0;
      end else if (take) begin
         phase_ff <= phase_in;
         rem_ff <= rem_in;
         cnt_ff <= cnt_in;
      end
   end

   `CBD_ASSERT_ALWAYS(a_reset_to_size, reset |=> (phase_ff == PH_SIZE && cnt_ff == '0), "reset did not return the parser to the size line")
   `CBD_ASSERT_CLK(a_data_left, (phase_ff == PH_DATA) |-> (rem_ff != '0), "data phase with no bytes left")
   `CBD_ASSERT_CLK(a_trail_count, (phase_ff == PH_TRAIL) |-> (cnt_ff == CntW'(1) || cnt_ff == CntW'(TrailBytes)), "trailer skip count out of range")
   `CBD_ASSERT_CLK(a_count_bound, cnt_ff <= CntW'(CntMax), "digit count beyond its limit")

endmodule

`default_nettype wire

@@ sv/cbd_output_stage.sv @@
`timescale 1ns / 1ps
`default_nettype none

module cbd_output_stage import cbd_pkg::*; (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       res_load,
   input  wire result_type res,
   output logic            out_free,
   cbd_rsp_if.source       rsp
);

   logic       out_valid_ff;
   logic       out_valid_in;
   result_type res_ff;

   assign out_free = !out_valid_ff || rsp.ready;
   assign out_valid_in = res_load || (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         res_ff <= res;
      end
   end

   assign rsp.valid = out_valid_ff;
   assign rsp.out_byte = res_ff.out_byte;
   assign rsp.kind = res_ff.kind;

endmodule

`default_nettype wire

@@ sv/http_chunked_body_decoder_top.sv @@
// Flow: a byte taken in a req transfer is decoded from the input register; its result,
// if any, is loaded into the result register and leaves from there in an rsp transfer.
// Throughput: one byte per cycle, set by the single parse step between the input
// register and the result register; a stalled result holds only bytes that give results.
// Reset (synchronous, active high) empties both registers and puts the parser
// at the start of a chunk size line with a zero size and digit count.
`timescale 1ns / 1ps
`default_nettype none

module http_chunked_body_decoder_top import cbd_pkg::*; #(
   parameter int unsigned SIZE_DIGITS = DefaultSizeDigits
) (
   input  wire logic clock,
   input  wire logic reset,
   cbd_req_if.sink   req_ch,
   cbd_rsp_if.source rsp_ch
);

   // The input register holds one body byte and its start flag. It accepts a
   // new transfer whenever it is empty or its byte moves on in the same cycle.
   logic       item_valid;
   item_type   item;

   // Handshake between the parser and the result register. A byte that gives
   // no result (size digits, extension, line ends, trailer, idle discard)
   // moves on even while the result register is full and stalled.
   logic       take;
   logic       res_load;
   logic       out_free;
   result_type res;

   cbd_input_stage u_input (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   // The parser keeps the phase, the chunk size or remaining byte count, and
   // the digit or trailer count, and updates them once per byte.
   cbd_parser #(
      .SIZE_DIGITS (SIZE_DIGITS)
   ) u_parser (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .out_free   (out_free),
      .take       (take),
      .res_load   (res_load),
      .res        (res)
   );

   // The result register presents payload bytes, the end-of-body mark and the
   // size overflow mark, and holds them until the rsp transfer completes.
   cbd_output_stage u_output (
      .clock    (clock),
      .reset    (reset),
      .res_load (res_load),
      .res      (res),
      .out_free (out_free),
      .rsp      (rsp_ch)
   );

endmodule

`default_nettype wire

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

// Bench for the chunked body decoder. Bytes go in through the req channel and
// every accepted transfer is run through a behavioral decoder kept here, which
// queues the result that the byte should cause. Every rsp transfer is checked
// field by field against the oldest queued result.
module testbench;
   import cbd_pkg::*;

   localparam int unsigned SizeDigits = DefaultSizeDigits;
   localparam int unsigned NumDirected = 28;
   localparam int unsigned RandomItems = 600;
   // Near the end neither side idles, so the last bytes flow back to back.
   localparam int unsigned TailItems = 100;
   // One long receiver hold-off, started after this many accepted bytes.
   localparam int unsigned LongHoldAt = NumDirected + 20;
   localparam int unsigned LongHoldCycles = 400;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned CycleLimit = 200000;

   // A row either takes its expected result from the decoder model below or
   // carries a result typed into the table.
   typedef enum logic {
      CHK_MODEL = 1'b0,
      CHK_FIXED = 1'b1
   } check_mode_type;

   typedef struct packed {
      logic [ByteW-1:0] data;
      logic             start;
      check_mode_type   mode;
      logic [ByteW-1:0] rbyte;
      kind_type         rkind;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   cbd_req_if req_ch ();
   cbd_rsp_if rsp_ch ();

   http_chunked_body_decoder_top #(
      .SIZE_DIGITS(SizeDigits)
   ) u_dut (
      .clock (clock),
      .reset (reset),
      .req_ch(req_ch),
      .rsp_ch(rsp_ch)
   );

   always #2 clock = ~clock;

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------
   // Decoder model: its own copy of the parse phase, the size being built
   // (then the data bytes still due) and the digit count (then the trailing
   // bytes still to skip).
   // ---------------------------------------------------------------------
   phase_type        dec_phase;
   logic [SizeW-1:0] dec_remaining;
   int unsigned      dec_count;

   function automatic void restart_size();
      dec_phase = PH_SIZE;
      dec_remaining = '0;
      dec_count = 0;
   endfunction

   // Hex digit value 0..15 in either case; HexInvalid for any other byte.
   function automatic logic [4:0] digit_of(input logic [ByteW-1:0] b);
      if (b >= "0" && b <= "9") begin
         return {1'b0, b[3:0]};
      end
      if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) begin
         return {1'b0, b[3:0]} + 5'd9;
      end
      return HexInvalid;
   endfunction

   // Advances the model by one byte. Returns 1 when the byte gives a result.
   function automatic bit decode_step(input logic [ByteW-1:0] b, input logic start,
                                      output result_type res);
      logic [4:0] d;
      res.out_byte = '0;
      res.kind = KIND_DATA;
      if (start) begin
         restart_size();
      end
      case (dec_phase)
         PH_SIZE: begin
            if (b == CharCr) begin
               dec_phase = PH_LF;
               return 1'b0;
            end
            d = digit_of(b);
            if (d == HexInvalid) begin
               dec_phase = PH_EXT;
               return 1'b0;
            end
            // The digit past the limit is dropped and the body is abandoned.
            if (dec_count >= SizeDigits) begin
               dec_phase = PH_IDLE;
               res.kind = KIND_OVF;
               return 1'b1;
            end
            dec_remaining = {dec_remaining[SizeW-5:0], d[3:0]};
            dec_count++;
            return 1'b0;
         end
         PH_EXT: begin
            if (b == CharCr) begin
               dec_phase = PH_LF;
            end
            return 1'b0;
         end
         PH_LF: begin
            if (b == CharLf) begin
               if (dec_remaining != 0) begin
                  dec_phase = PH_DATA;
                  return 1'b0;
               end
               dec_phase = PH_IDLE;
               res.kind = KIND_END;
               return 1'b1;
            end
            // A repeated CR keeps waiting for LF; anything else is extension.
            if (b != CharCr) begin
               dec_phase = PH_EXT;
            end
            return 1'b0;
         end
         PH_DATA: begin
            res.out_byte = b;
            dec_remaining--;
            if (dec_remaining == 0) begin
               dec_phase = PH_TRAIL;
               dec_count = TrailBytes;
            end
            return 1'b1;
         end
         PH_TRAIL: begin
            if (dec_count > 0) begin
               dec_count--;
            end
            if (dec_count == 0) begin
               restart_size();
            end
            return 1'b0;
         end
         default: begin
            return 1'b0;
         end
      endcase
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus. The directed table comes first; random bodies follow.
   // ---------------------------------------------------------------------
   row_type directed_rows [0:NumDirected-1];
   row_type stim_q [$];
   bit      next_start;

   function automatic void put(input logic [ByteW-1:0] b);
      row_type row;
      row.data = b;
      row.start = next_start;
      row.mode = CHK_MODEL;
      row.rbyte = '0;
      row.rkind = KIND_DATA;
      stim_q.insert(stim_q.size(), row);
      next_start = 1'b0;
   endfunction

   function automatic logic [ByteW-1:0] hex_char(input logic [3:0] v);
      if (v < 4'd10) begin
         return "0" + v;
      end
      return ($urandom_range(0, 1) ? "a" : "A") + v - 8'd10;
   endfunction

   // Size line digits, sometimes with leading zeros that still count toward
   // the digit limit.
   function automatic void put_size(input int unsigned size);
      int unsigned ndig;
      int unsigned v;
      int unsigned lead;
      int i;
      ndig = 0;
      v = size;
      do begin
         ndig++;
         v = v >> 4;
      end while (v != 0);
      lead = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SizeDigits - ndig) : 0;
      for (i = 0; i < lead; i++) begin
         put("0");
      end
      for (i = ndig - 1; i >= 0; i--) begin
         put(hex_char(4'(size >> (4 * i))));
      end
   endfunction

   // Any byte that is neither a hex digit nor CR opens an extension.
   function automatic logic [ByteW-1:0] ext_mark();
      logic [ByteW-1:0] b;
      do begin
         b = ByteW'($urandom_range(0, 255));
      end while (b == CharCr || digit_of(b) != HexInvalid);
      return b;
   endfunction

   function automatic void maybe_ext();
      logic [ByteW-1:0] b;
      int unsigned n;
      int unsigned i;
      if ($urandom_range(0, 3) == 0) begin
         put(ext_mark());
         n = $urandom_range(0, 5);
         for (i = 0; i < n; i++) begin
            do begin
               b = ByteW'($urandom_range(0, 255));
            end while (b == CharCr);
            put(b);
         end
      end
   endfunction

   // A well-formed body: a few small chunks, the zero chunk and some footer.
   function automatic void gen_body();
      int unsigned chunks;
      int unsigned size;
      int unsigned n;
      int unsigned c;
      int unsigned j;
      next_start = 1'b1;
      chunks = $urandom_range(0, 3);
      for (c = 0; c < chunks; c++) begin
         size = ($urandom_range(0, 19) < 14) ? $urandom_range(1, 8) : $urandom_range(9, 40);
         put_size(size);
         maybe_ext();
         put(CharCr);
         put(CharLf);
         for (j = 0; j < size; j++) begin
            put(ByteW'($urandom_range(0, 255)));
         end
         // The two bytes after the data are skipped whatever they hold.
         if ($urandom_range(0, 4) != 0) begin
            put(CharCr);
            put(CharLf);
         end else begin
            put(ByteW'($urandom_range(0, 255)));
            put(ByteW'($urandom_range(0, 255)));
         end
      end
      // The last size line is sometimes empty, which also ends the body.
      if ($urandom_range(0, 4) != 0) begin
         put_size(0);
      end
      maybe_ext();
      put(CharCr);
      put(CharLf);
      n = $urandom_range(0, 6);
      for (j = 0; j < n; j++) begin
         put(ByteW'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void gen_overflow();
      int unsigned n;
      int unsigned j;
      next_start = 1'b1;
      n = SizeDigits + $urandom_range(1, 2);
      for (j = 0; j < n; j++) begin
         put(hex_char(4'($urandom_range(0, 15))));
      end
      n = $urandom_range(0, 4);
      for (j = 0; j < n; j++) begin
         put(ByteW'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void gen_noise();
      int unsigned n;
      int unsigned j;
      n = $urandom_range(3, 12);
      for (j = 0; j < n; j++) begin
         next_start = ($urandom_range(0, 7) == 0);
         put(ByteW'($urandom_range(0, 255)));
      end
   endfunction

   function automatic void build_stimulus();
      int unsigned i;
      int unsigned sel;
      int unsigned mark;
      int unsigned cut;
      // Directed part: no start flag after reset, a one-byte chunk, an empty
      // size line opened by an extension; then LF without CR, CR repeated,
      // CR followed by another byte, junk trailing bytes; then every hex digit
      // extreme after a leading zero, up to one digit beyond the limit.
      directed_rows = '{
         '{"1",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharCr, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharLf, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{8'hff,  1'b0, CHK_FIXED, 8'hff, KIND_DATA},
         '{CharCr, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharLf, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{";",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharCr, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharLf, 1'b0, CHK_FIXED, 8'h00, KIND_END},
         '{"1",    1'b1, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharLf, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharCr, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharCr, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"x",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharCr, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{CharLf, 1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{8'h00,  1'b0, CHK_FIXED, 8'h00, KIND_DATA},
         '{"Z",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"Z",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"0",    1'b1, CHK_MODEL, 8'h00, KIND_DATA},
         '{"9",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"a",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"f",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"A",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"F",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"0",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"0",    1'b0, CHK_MODEL, 8'h00, KIND_DATA},
         '{"7",    1'b0, CHK_FIXED, 8'h00, KIND_OVF}
      };
      for (i = 0; i < NumDirected; i++) begin
         stim_q.insert(stim_q.size(), directed_rows[i]);
      end
      // Random part: mostly well-formed bodies, some of them cut short by the
      // next body's start, plus overflowing sizes and raw noise.
      while (stim_q.size() < NumDirected + RandomItems) begin
         sel = $urandom_range(0, 19);
         if (sel < 14) begin
            mark = stim_q.size();
            gen_body();
            if ($urandom_range(0, 6) == 0 && stim_q.size() > mark + 1) begin
               cut = $urandom_range(1, stim_q.size() - mark - 1);
               repeat (cut) void'(stim_q.pop_back());
            end
         end else if (sel < 17) begin
            gen_overflow();
         end else begin
            gen_noise();
         end
      end
   endfunction

   // ---------------------------------------------------------------------
   // Scoreboard: predicts at every req transfer, checks at every rsp transfer.
   // ---------------------------------------------------------------------
   result_type  decoded_q [$];
   int unsigned taken_count = 0;
   int unsigned error_count = 0;

   always @(posedge clock) begin : track
      row_type    row;
      result_type want;
      bit         has;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            row = stim_q[taken_count];
            has = decode_step(row.data, row.start, want);
            if (row.mode == CHK_FIXED) begin
               has = 1'b1;
               want.out_byte = row.rbyte;
               want.kind = row.rkind;
            end
            if (has) begin
               decoded_q.insert(decoded_q.size(), want);
            end
            taken_count++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (decoded_q.size() == 0) begin
               $error("result with none expected: out_byte %0h, kind %0d",
                      rsp_ch.out_byte, rsp_ch.kind);
               error_count++;
            end else begin
               want = decoded_q.pop_front();
               if (rsp_ch.out_byte !== want.out_byte) begin
                  $error("out_byte mismatch: expected %0h, actual %0h",
                         want.out_byte, rsp_ch.out_byte);
                  error_count++;
               end
               if (rsp_ch.kind !== want.kind) begin
                  $error("kind mismatch: expected %0d, actual %0d", want.kind, rsp_ch.kind);
                  error_count++;
               end
            end
         end
      end
   end

   // Sender. Gaps come in bursts, none during every fourth stretch of 64 bytes
   // and none in the tail. When the next byte follows without a gap, valid
   // simply stays high, so it gets a single assignment in that time step.
   initial begin : sender
      int unsigned idx;
      int unsigned gap;
      restart_size();
      build_stimulus();
      req_ch.valid <= 1'b0;
      req_ch.in_byte <= '0;
      req_ch.body_start <= 1'b0;
      do @(posedge clock); while (reset);
      idx = 0;
      while (idx < stim_q.size()) begin
         gap = 0;
         if (idx + TailItems < stim_q.size() && ((idx / 64) % 4) != 3
             && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 15);
         end
         if (gap != 0) begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_ch.valid <= 1'b1;
         req_ch.in_byte <= stim_q[idx].data;
         req_ch.body_start <= stim_q[idx].start;
         @(posedge clock);
         while (!req_ch.ready) @(posedge clock);
         idx++;
      end
      req_ch.valid <= 1'b0;
      // A byte without a result can still be in flight when the queue drains,
      // so a few more cycles catch any stray result.
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   // Receiver. One long hold-off early in the random part lets the block fill
   // up and push back on the sender; otherwise stalls come in short bursts.
   initial begin : receiver
      int unsigned hold;
      bit          long_done;
      long_done = 1'b0;
      rsp_ch.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (taken_count + TailItems >= stim_q.size()) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else if (!long_done && taken_count >= LongHoldAt) begin
            long_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LongHoldCycles) @(posedge clock);
         end else if (((taken_count / 64) % 4) == 3 || $urandom_range(0, 4) != 0) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            hold = $urandom_range(1, 15);
            rsp_ch.ready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
      end
   end

   // Watchdog against a hung handshake.
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CycleLimit) begin
         $display("TB_ERROR");
         $finish;
      end
   end

endmodule
